// File: hdl/frac_n_pll_register_calc_defines.svh
// Assertion macros used by the checker of this block.
`ifndef FRAC_N_PLL_REGISTER_CALC_DEFINES_SVH
`define FRAC_N_PLL_REGISTER_CALC_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define FNPLL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define FNPLL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fnpll_pkg.sv
package fnpll_pkg;

    localparam logic [31:0] MIN_FREQ_DEFAULT = 32'd35000000;
    localparam logic [39:0] LO_TARGET        = 40'd2200000000;
    localparam logic [39:0] PRESCALE_EDGE    = 40'd3600000000;
    localparam logic [2:0]  SEL_MAX          = 3'd6;
    localparam logic [28:0] MOD_MIN          = 29'd2;
    localparam logic [28:0] MOD_MAX          = 29'd4095;
    localparam logic [15:0] INT_MIN_P0       = 16'd23;
    localparam logic [15:0] INT_MIN_P1       = 16'd75;
    localparam logic [15:0] INT_SAT          = 16'hFFFF;
    localparam logic [2:0]  LAST_INDEX       = 3'd5;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_LOW  = 3'd1,
        ST_MOD  = 3'd2,
        ST_FRAC = 3'd3,
        ST_INT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CFG_REF_FREQ    = 3'd0,
        CFG_REF_COUNTER = 3'd1,
        CFG_REF_DOUBLER = 3'd2,
        CFG_REF_HALVE   = 3'd3,
        CFG_CHAN_STEP   = 3'd4,
        CFG_CLOCK_DIV   = 3'd5,
        CFG_OUT_POWER   = 3'd6,
        CFG_BAND_SEL    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [27:0] ref_hz;
        logic [9:0]  ref_counter;
        logic        ref_doubler;
        logic        ref_halve;
        logic [19:0] channel_step;
        logic [11:0] clock_divider;
        logic [1:0]  output_power;
        logic [7:0]  band_select_div;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEL,
        OP_MUL1,
        OP_DIVN,
        OP_DIVM,
        OP_MUL2,
        OP_DIVF,
        OP_GCD_LD,
        OP_GCD,
        OP_DIVFG,
        OP_DIVMG,
        OP_CHECK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sel_done;
        logic low;
        logic bad_cfg;
        logic div_done;
        logic frac_zero;
        logic gcd_done;
        logic err;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEL,
        S_MUL1,
        S_DIVN,
        S_DIVN_W,
        S_DIVM,
        S_DIVM_W,
        S_MUL2,
        S_DIVF,
        S_DIVF_W,
        S_GCD_LD,
        S_GCD,
        S_DIVFG,
        S_DIVFG_W,
        S_DIVMG,
        S_DIVMG_W,
        S_CHECK,
        S_EMIT
    } state_t;

endpackage

// File: hdl/fnpll_div.sv
module fnpll_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [6:0]  nbits,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quot,
    output logic [31:0] remainder
);

    logic [63:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        fits;

    // dividend arrives left-aligned; one quotient bit per cycle
    assign trial = {r_reg, q_reg[63]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            dvs_next = divisor;
            cnt_next = nbits;
        end
        else if (cnt_reg != '0)
        begin
            r_next    = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            q_next    = {q_reg[62:0], fits};
            cnt_next  = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quot      = q_reg;
    assign remainder = r_reg;

endmodule

// File: hdl/fnpll_dp.sv
module fnpll_dp #(
    parameter logic [31:0] MIN_FREQ_HZ = fnpll_pkg::MIN_FREQ_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fnpll_pkg::dp_cmd_t cmd,
    input  logic [31:0]        in_freq,
    input  fnpll_pkg::cfg_t    cfg,
    input  logic [2:0]         idx,
    output fnpll_pkg::dp_stat_t stat,
    output logic [31:0]        word,
    output logic [2:0]         status
);

    typedef enum logic [2:0] {
        DD_N,
        DD_M,
        DD_F,
        DD_FG,
        DD_MG
    } div_dest_t;

    logic [31:0] freq_reg;
    logic [2:0]  sel_reg;
    logic [50:0] prod_reg;
    logic [30:0] dm_reg;
    logic [50:0] nint_reg;
    logic [28:0] rem_reg;
    logic [28:0] mod_reg;
    logic [28:0] frac_reg;
    logic [59:0] t_reg;
    logic [28:0] ga_reg;
    logic [28:0] gb_reg;
    logic [4:0]  gk_reg;
    div_dest_t   dest_reg;
    fnpll_pkg::status_t status_reg, status_next;

    logic [28:0] num_p;
    logic [9:0]  rval;
    logic [10:0] den_p;
    logic [39:0] fsh;
    logic        pres;
    logic [50:0] prod_c;
    logic [30:0] dm_c;
    logic [57:0] rm_c;
    logic [28:0] g;
    logic [15:0] nsat;
    logic        fz;

    logic        dv_start;
    logic [63:0] dv_dvd;
    logic [6:0]  dv_n;
    logic [31:0] dv_dvs;
    logic        dv_done;
    logic [63:0] dv_q;
    logic [31:0] dv_r;

    assign num_p  = cfg.ref_doubler ? {cfg.ref_hz, 1'b0} : {1'b0, cfg.ref_hz};
    assign rval   = (cfg.ref_counter == '0) ? 10'd1 : cfg.ref_counter;
    assign den_p  = cfg.ref_halve ? {rval, 1'b0} : {1'b0, rval};
    assign fsh    = {8'b0, freq_reg} << sel_reg;
    assign pres   = fsh > fnpll_pkg::PRESCALE_EDGE;
    assign prod_c = 51'(fsh) * 51'(den_p);
    assign dm_c   = 31'(den_p) * 31'(cfg.channel_step);
    assign rm_c   = 58'(rem_reg) * 58'(mod_reg);
    assign g      = ga_reg << gk_reg;
    assign nsat   = (nint_reg[50:16] != '0) ? fnpll_pkg::INT_SAT : nint_reg[15:0];
    assign fz     = (frac_reg == '0);

    always_comb
    begin
        dv_start = 1'b0;
        dv_dvd   = '0;
        dv_n     = '0;
        dv_dvs   = '0;
        case (cmd.op)
            fnpll_pkg::OP_DIVN:
            begin
                dv_start = 1'b1;
                dv_dvd   = {prod_reg, 13'b0};
                dv_n     = 7'd51;
                dv_dvs   = {3'b0, num_p};
            end
            fnpll_pkg::OP_DIVM:
            begin
                dv_start = 1'b1;
                dv_dvd   = {num_p, 35'b0};
                dv_n     = 7'd29;
                dv_dvs   = {1'b0, dm_reg};
            end
            fnpll_pkg::OP_DIVF:
            begin
                dv_start = 1'b1;
                dv_dvd   = {t_reg, 4'b0};
                dv_n     = 7'd60;
                dv_dvs   = {2'b0, num_p, 1'b0};
            end
            fnpll_pkg::OP_DIVFG:
            begin
                dv_start = 1'b1;
                dv_dvd   = {frac_reg, 35'b0};
                dv_n     = 7'd29;
                dv_dvs   = {3'b0, g};
            end
            fnpll_pkg::OP_DIVMG:
            begin
                dv_start = 1'b1;
                dv_dvd   = {mod_reg, 35'b0};
                dv_n     = 7'd29;
                dv_dvs   = {3'b0, g};
            end
            default:
            begin
                dv_start = 1'b0;
            end
        endcase
    end

    fnpll_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (dv_dvd),
        .nbits     (dv_n),
        .divisor   (dv_dvs),
        .done      (dv_done),
        .quot      (dv_q),
        .remainder (dv_r)
    );

    // checks run in a fixed priority order
    always_comb
    begin
        if (freq_reg < MIN_FREQ_HZ)
            status_next = fnpll_pkg::ST_LOW;
        else if (num_p == '0 || cfg.channel_step == '0 || mod_reg < fnpll_pkg::MOD_MIN
                 || mod_reg > fnpll_pkg::MOD_MAX)
            status_next = fnpll_pkg::ST_MOD;
        else if (frac_reg > mod_reg - 29'd1)
            status_next = fnpll_pkg::ST_FRAC;
        else if ((!pres && nsat < fnpll_pkg::INT_MIN_P0)
                 || (pres && nsat < fnpll_pkg::INT_MIN_P1))
            status_next = fnpll_pkg::ST_INT;
        else
            status_next = fnpll_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= fnpll_pkg::ST_OK;
        else if (cmd.op == fnpll_pkg::OP_CHECK)
            status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            fnpll_pkg::OP_LOAD:
            begin
                freq_reg <= in_freq;
                sel_reg  <= '0;
            end
            fnpll_pkg::OP_SEL:
            begin
                if (!stat.sel_done)
                    sel_reg <= sel_reg + 3'd1;
            end
            fnpll_pkg::OP_MUL1:
            begin
                prod_reg <= prod_c;
                dm_reg   <= dm_c;
            end
            fnpll_pkg::OP_DIVN:  dest_reg <= DD_N;
            fnpll_pkg::OP_DIVM:  dest_reg <= DD_M;
            fnpll_pkg::OP_DIVF:  dest_reg <= DD_F;
            fnpll_pkg::OP_DIVFG: dest_reg <= DD_FG;
            fnpll_pkg::OP_DIVMG: dest_reg <= DD_MG;
            fnpll_pkg::OP_MUL2:
            begin
                // 2*rem*mod + num_p, rounding numerator
                t_reg <= 60'({rm_c, 1'b0}) + 60'(num_p);
            end
            fnpll_pkg::OP_GCD_LD:
            begin
                ga_reg <= frac_reg;
                gb_reg <= mod_reg;
                gk_reg <= '0;
            end
            fnpll_pkg::OP_GCD:
            begin
                // binary gcd, one step per cycle
                if (ga_reg != gb_reg)
                begin
                    if (!ga_reg[0] && !gb_reg[0])
                    begin
                        ga_reg <= ga_reg >> 1;
                        gb_reg <= gb_reg >> 1;
                        gk_reg <= gk_reg + 5'd1;
                    end
                    else if (!ga_reg[0])
                        ga_reg <= ga_reg >> 1;
                    else if (!gb_reg[0])
                        gb_reg <= gb_reg >> 1;
                    else if (ga_reg > gb_reg)
                        ga_reg <= ga_reg - gb_reg;
                    else
                        gb_reg <= gb_reg - ga_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (dv_done)
        begin
            case (dest_reg)
                DD_N:
                begin
                    nint_reg <= dv_q[50:0];
                    rem_reg  <= dv_r[28:0];
                end
                DD_M:    mod_reg  <= dv_q[28:0];
                DD_F:    frac_reg <= dv_q[28:0];
                DD_FG:   frac_reg <= dv_q[28:0];
                DD_MG:   mod_reg  <= dv_q[28:0];
                default: mod_reg  <= mod_reg;
            endcase
        end
    end

    always_comb
    begin
        word = '0;
        if (status_reg == fnpll_pkg::ST_OK)
        begin
            case (idx)
                3'd0: word = {1'b0, nsat, frac_reg[11:0], 3'd0};
                3'd1: word = 32'd1 | (32'(mod_reg[11:0]) << 3) | (32'd1 << 15)
                             | (32'(pres) << 27);
                3'd2: word = 32'd2 | (32'd1 << 6) | (32'd7 << 9)
                             | (32'(cfg.ref_counter) << 14) | (32'(cfg.ref_halve) << 24)
                             | (32'(cfg.ref_doubler) << 25) | (fz ? (32'd3 << 7) : 32'd0);
                3'd3: word = 32'd3 | (32'(cfg.clock_divider) << 3) | (32'd1 << 23)
                             | (fz ? (32'd3 << 21) : 32'd0);
                3'd4: word = 32'd4 | (32'(cfg.output_power) << 3) | (32'd1 << 5)
                             | (32'(cfg.band_select_div) << 12) | (32'(sel_reg) << 20)
                             | (32'd1 << 23);
                3'd5: word = 32'd5 | (32'd3 << 19) | (32'd1 << 22);
                default: word = '0;
            endcase
        end
    end

    assign status = status_reg;

    assign stat.sel_done  = (fsh > fnpll_pkg::LO_TARGET) || (sel_reg > fnpll_pkg::SEL_MAX);
    assign stat.low       = freq_reg < MIN_FREQ_HZ;
    assign stat.bad_cfg   = (num_p == '0) || (cfg.channel_step == '0);
    assign stat.div_done  = dv_done;
    assign stat.frac_zero = fz;
    assign stat.gcd_done  = (ga_reg == gb_reg);
    assign stat.err       = (status_reg != fnpll_pkg::ST_OK);

endmodule

// File: hdl/fnpll_ctrl.sv
module fnpll_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    input  fnpll_pkg::dp_stat_t stat,
    output fnpll_pkg::dp_cmd_t  cmd,
    output logic                in_ready,
    output logic                out_valid,
    output logic                out_last,
    output logic [2:0]          out_index
);

    fnpll_pkg::state_t state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            fnpll_pkg::S_IDLE:
                if (in_valid)
                    state_next = fnpll_pkg::S_SEL;
            fnpll_pkg::S_SEL:
                if (stat.low || stat.bad_cfg)
                    state_next = fnpll_pkg::S_CHECK;
                else if (stat.sel_done)
                    state_next = fnpll_pkg::S_MUL1;
            fnpll_pkg::S_MUL1:   state_next = fnpll_pkg::S_DIVN;
            fnpll_pkg::S_DIVN:   state_next = fnpll_pkg::S_DIVN_W;
            fnpll_pkg::S_DIVN_W:
                if (stat.div_done)
                    state_next = fnpll_pkg::S_DIVM;
            fnpll_pkg::S_DIVM:   state_next = fnpll_pkg::S_DIVM_W;
            fnpll_pkg::S_DIVM_W:
                if (stat.div_done)
                    state_next = fnpll_pkg::S_MUL2;
            fnpll_pkg::S_MUL2:   state_next = fnpll_pkg::S_DIVF;
            fnpll_pkg::S_DIVF:   state_next = fnpll_pkg::S_DIVF_W;
            fnpll_pkg::S_DIVF_W:
                if (stat.div_done)
                    state_next = fnpll_pkg::S_GCD_LD;
            fnpll_pkg::S_GCD_LD:
                state_next = stat.frac_zero ? fnpll_pkg::S_CHECK : fnpll_pkg::S_GCD;
            fnpll_pkg::S_GCD:
                if (stat.gcd_done)
                    state_next = fnpll_pkg::S_DIVFG;
            fnpll_pkg::S_DIVFG:  state_next = fnpll_pkg::S_DIVFG_W;
            fnpll_pkg::S_DIVFG_W:
                if (stat.div_done)
                    state_next = fnpll_pkg::S_DIVMG;
            fnpll_pkg::S_DIVMG:  state_next = fnpll_pkg::S_DIVMG_W;
            fnpll_pkg::S_DIVMG_W:
                if (stat.div_done)
                    state_next = fnpll_pkg::S_CHECK;
            fnpll_pkg::S_CHECK:
            begin
                state_next = fnpll_pkg::S_EMIT;
                idx_next   = fnpll_pkg::LAST_INDEX;
            end
            fnpll_pkg::S_EMIT:
                if (out_ready)
                begin
                    if (out_last)
                        state_next = fnpll_pkg::S_IDLE;
                    else
                        idx_next = idx_reg - 3'd1;
                end
            default: state_next = fnpll_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = fnpll_pkg::OP_NONE;
        unique case (state_reg)
            fnpll_pkg::S_IDLE:    cmd.op = in_valid ? fnpll_pkg::OP_LOAD : fnpll_pkg::OP_NONE;
            fnpll_pkg::S_SEL:     cmd.op = fnpll_pkg::OP_SEL;
            fnpll_pkg::S_MUL1:    cmd.op = fnpll_pkg::OP_MUL1;
            fnpll_pkg::S_DIVN:    cmd.op = fnpll_pkg::OP_DIVN;
            fnpll_pkg::S_DIVM:    cmd.op = fnpll_pkg::OP_DIVM;
            fnpll_pkg::S_MUL2:    cmd.op = fnpll_pkg::OP_MUL2;
            fnpll_pkg::S_DIVF:    cmd.op = fnpll_pkg::OP_DIVF;
            fnpll_pkg::S_GCD_LD:  cmd.op = fnpll_pkg::OP_GCD_LD;
            fnpll_pkg::S_GCD:     cmd.op = fnpll_pkg::OP_GCD;
            fnpll_pkg::S_DIVFG:   cmd.op = fnpll_pkg::OP_DIVFG;
            fnpll_pkg::S_DIVMG:   cmd.op = fnpll_pkg::OP_DIVMG;
            fnpll_pkg::S_CHECK:   cmd.op = fnpll_pkg::OP_CHECK;
            default:              cmd.op = fnpll_pkg::OP_NONE;
        endcase
    end

    assign in_ready  = (state_reg == fnpll_pkg::S_IDLE);
    assign out_valid = (state_reg == fnpll_pkg::S_EMIT);
    assign out_last  = stat.err || (idx_reg == '0);
    assign out_index = stat.err ? 3'd0 : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fnpll_pkg::S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: hdl/frac_n_pll_register_calc.sv
// Flow: an item below the minimum frequency, or with a zero reference or channel
// step, skips the divisions and goes straight to the check and its error item;
// otherwise the words follow the serial divisions (serial divider, 1 bit/cycle), plus
// a binary gcd reduction and two more divisions when the fraction is not zero.
// Throughput: one item at a time; the next is taken after its last word is delivered.
// Reset: asynchronous, clears the controller and loads the configuration defaults.
module frac_n_pll_register_calc #(
    parameter logic [31:0] MIN_FREQ_HZ = fnpll_pkg::MIN_FREQ_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] target_freq
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] reg_word
    output logic [5:0]  m_tuser,    // [2:0] reg_index, [5:3] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [27:0] cfg_data
);

    fnpll_pkg::cfg_t     cfg_reg;
    fnpll_pkg::dp_cmd_t  cmd;
    fnpll_pkg::dp_stat_t stat;
    logic [2:0]          out_index;
    logic [2:0]          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_hz          <= 28'd25000000;
            cfg_reg.ref_counter     <= 10'd1;
            cfg_reg.ref_doubler     <= 1'b0;
            cfg_reg.ref_halve       <= 1'b0;
            cfg_reg.channel_step    <= 20'd100000;
            cfg_reg.clock_divider   <= 12'd150;
            cfg_reg.output_power    <= 2'd3;
            cfg_reg.band_select_div <= 8'd80;
        end
        else if (cfg_we)
        begin
            unique case (fnpll_pkg::cfg_idx_t'(cfg_index))
                fnpll_pkg::CFG_REF_FREQ:    cfg_reg.ref_hz          <= cfg_data;
                fnpll_pkg::CFG_REF_COUNTER: cfg_reg.ref_counter     <= cfg_data[9:0];
                fnpll_pkg::CFG_REF_DOUBLER: cfg_reg.ref_doubler     <= cfg_data[0];
                fnpll_pkg::CFG_REF_HALVE:   cfg_reg.ref_halve       <= cfg_data[0];
                fnpll_pkg::CFG_CHAN_STEP:   cfg_reg.channel_step    <= cfg_data[19:0];
                fnpll_pkg::CFG_CLOCK_DIV:   cfg_reg.clock_divider   <= cfg_data[11:0];
                fnpll_pkg::CFG_OUT_POWER:   cfg_reg.output_power    <= cfg_data[1:0];
                fnpll_pkg::CFG_BAND_SEL:    cfg_reg.band_select_div <= cfg_data[7:0];
                default:                    cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    fnpll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .out_index (out_index)
    );

    fnpll_dp #(
        .MIN_FREQ_HZ (MIN_FREQ_HZ)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_freq (s_tdata),
        .cfg     (cfg_reg),
        .idx     (out_index),
        .stat    (stat),
        .word    (m_tdata),
        .status  (status)
    );

    assign m_tuser = {status, out_index};

endmodule

// File: hdl/fnpll_checker.sv
`include "frac_n_pll_register_calc_defines.svh"

module fnpll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [5:0]  m_tuser,
    input logic        m_tlast
);

    `FNPLL_ASSERT(a_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")
    `FNPLL_ASSERT(a_err_single, clk, rst_n, m_tvalid && m_tuser[5:3] != fnpll_pkg::ST_OK |-> m_tlast && m_tdata == '0 && m_tuser[2:0] == '0, "error item malformed")
    `FNPLL_ASSERT(a_one_at_time, clk, rst_n, m_tvalid |-> !s_tready, "input taken while results pending")
    `FNPLL_ASSERT(a_burst, clk, rst_n, m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[2:0] == $past(m_tuser[2:0]) - 3'd1, "word sequence broken")
    `FNPLL_ASSERT_ALWAYS(a_reset, clk, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind frac_n_pll_register_calc fnpll_checker u_fnpll_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
